// File: hw/rtl/bls_pkg.sv
package bls_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int ERR_WIDTH   = COORD_WIDTH + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [ERR_WIDTH-1:0]   err_t;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    // Classified transaction handed from the front end to the stepper
    typedef struct packed {
        func_t  func;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t abs_dx;
        coord_t abs_dy;
        logic   x_step_down;
        logic   y_step_down;
    } cmd_t;

    function automatic coord_t step_coord(input coord_t c, input logic down);
        coord_t r;
        if (down)
        begin
            r = c - coord_t'(1);
        end
        else
        begin
            r = c + coord_t'(1);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bls_front.sv
module bls_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            func,
    input  bls_pkg::coord_t start_x,
    input  bls_pkg::coord_t start_y,
    input  bls_pkg::coord_t end_x,
    input  bls_pkg::coord_t end_y,
    output logic            push_valid,
    input  logic            push_ready,
    output bls_pkg::cmd_t   push_cmd
);

    logic x_down;
    logic y_down;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    assign x_down = (end_x < start_x);
    assign y_down = (end_y < start_y);

    always_comb
    begin
        push_cmd.func        = bls_pkg::func_t'(func);
        push_cmd.start_x     = start_x;
        push_cmd.start_y     = start_y;
        push_cmd.end_x       = end_x;
        push_cmd.end_y       = end_y;
        push_cmd.x_step_down = x_down;
        push_cmd.y_step_down = y_down;
        push_cmd.abs_dx      = x_down ? (start_x - end_x) : (end_x - start_x);
        push_cmd.abs_dy      = y_down ? (start_y - end_y) : (end_y - start_y);
    end

endmodule

// File: hw/rtl/bls_queue.sv
module bls_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bls_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bls_pkg::cmd_t pop_cmd
);

    bls_pkg::cmd_t mem [bls_pkg::QUEUE_DEPTH];

    logic [bls_pkg::QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bls_pkg::QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bls_pkg::QCNT_WIDTH-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != bls_pkg::QCNT_WIDTH'(bls_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [bls_pkg::QPTR_WIDTH-1:0] ptr_inc(
        input logic [bls_pkg::QPTR_WIDTH-1:0] p
    );
        logic [bls_pkg::QPTR_WIDTH-1:0] r;
        if (p == bls_pkg::QPTR_WIDTH'(bls_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + bls_pkg::QPTR_WIDTH'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + bls_pkg::QCNT_WIDTH'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - bls_pkg::QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/bls_back.sv
module bls_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  bls_pkg::cmd_t   pop_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output bls_pkg::coord_t pixel_x,
    output bls_pkg::coord_t pixel_y,
    output logic            last_pixel
);

    bls_pkg::coord_t cur_x_reg, cur_x_next;
    bls_pkg::coord_t cur_y_reg, cur_y_next;
    bls_pkg::coord_t stop_major_reg, stop_major_next;
    bls_pkg::err_t   error_term_reg, error_term_next;
    bls_pkg::coord_t abs_dx_reg, abs_dx_next;
    bls_pkg::coord_t abs_dy_reg, abs_dy_next;
    logic            x_step_down_reg, x_step_down_next;
    logic            y_step_down_reg, y_step_down_next;
    logic            x_major_reg, x_major_next;
    logic            busy_reg, busy_next;

    logic            out_valid_reg, out_valid_next;
    bls_pkg::coord_t pixel_x_reg, pixel_x_next;
    bls_pkg::coord_t pixel_y_reg, pixel_y_next;
    logic            last_reg, last_next;

    logic            head_is_load;
    logic            out_free;
    logic            take;
    logic            emit;

    logic            ld_x_major;
    bls_pkg::coord_t ld_major;
    bls_pkg::coord_t ld_minor;

    bls_pkg::coord_t st_major;
    bls_pkg::coord_t st_minor;
    logic            err_pos;
    bls_pkg::coord_t x_stepped;
    bls_pkg::coord_t y_stepped;
    bls_pkg::coord_t major_after;

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = head_is_load || !busy_reg || out_free;
    assign take      = pop_valid && pop_ready;
    assign emit      = take && !head_is_load && busy_reg;

    always_comb
    begin
        case (pop_cmd.func)
            bls_pkg::FUNC_LOAD:    head_is_load = 1'b1;
            bls_pkg::FUNC_ADVANCE: head_is_load = 1'b0;
            default:               head_is_load = 1'b0;
        endcase
    end

    // Segment setup
    assign ld_x_major = (pop_cmd.abs_dx > pop_cmd.abs_dy);
    assign ld_major   = ld_x_major ? pop_cmd.abs_dx : pop_cmd.abs_dy;
    assign ld_minor   = ld_x_major ? pop_cmd.abs_dy : pop_cmd.abs_dx;

    // Per-pixel step
    assign st_major    = x_major_reg ? abs_dx_reg : abs_dy_reg;
    assign st_minor    = x_major_reg ? abs_dy_reg : abs_dx_reg;
    assign err_pos     = !error_term_reg[bls_pkg::ERR_WIDTH-1] && (error_term_reg != '0);
    assign x_stepped   = bls_pkg::step_coord(cur_x_reg, x_step_down_reg);
    assign y_stepped   = bls_pkg::step_coord(cur_y_reg, y_step_down_reg);
    assign major_after = x_major_reg ? x_stepped : y_stepped;

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        stop_major_next  = stop_major_reg;
        error_term_next  = error_term_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        x_step_down_next = x_step_down_reg;
        y_step_down_next = y_step_down_reg;
        x_major_next     = x_major_reg;
        busy_next        = busy_reg;

        if (take && head_is_load)
        begin
            cur_x_next       = pop_cmd.start_x;
            cur_y_next       = pop_cmd.start_y;
            abs_dx_next      = pop_cmd.abs_dx;
            abs_dy_next      = pop_cmd.abs_dy;
            x_step_down_next = pop_cmd.x_step_down;
            y_step_down_next = pop_cmd.y_step_down;
            x_major_next     = ld_x_major;
            stop_major_next  = ld_x_major ? pop_cmd.end_x : pop_cmd.end_y;
            error_term_next  = {2'b00, ld_minor, 1'b0} - {3'b000, ld_major};
            busy_next        = (ld_major != '0);
        end
        else if (emit)
        begin
            error_term_next = error_term_reg + {2'b00, st_minor, 1'b0}
                              - (err_pos ? {2'b00, st_major, 1'b0} : '0);
            if (x_major_reg)
            begin
                cur_x_next = x_stepped;
                cur_y_next = err_pos ? y_stepped : cur_y_reg;
            end
            else
            begin
                cur_y_next = y_stepped;
                cur_x_next = err_pos ? x_stepped : cur_x_reg;
            end
            busy_next = (major_after != stop_major_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pixel_x_next   = cur_x_reg;
            pixel_y_next   = cur_y_reg;
            last_next      = (major_after == stop_major_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stop_major_reg  <= '0;
            error_term_reg  <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            x_step_down_reg <= 1'b0;
            y_step_down_reg <= 1'b0;
            x_major_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            stop_major_reg  <= stop_major_next;
            error_term_reg  <= error_term_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            x_step_down_reg <= x_step_down_next;
            y_step_down_reg <= y_step_down_next;
            x_major_reg     <= x_major_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/bresenham_line_stepper_top.sv
// An accepted advance transaction passes the queue and the output register to a pixel.
// Throughput: one transaction per cycle unless the output stalls; the stepper error
// update and coordinate step are combinational, decoupled by a two-entry queue.
// Reset (rst_n, async active low): queue empty, stepper idle, no output pending.
module bresenham_line_stepper_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            func,
    input  bls_pkg::coord_t start_x,
    input  bls_pkg::coord_t start_y,
    input  bls_pkg::coord_t end_x,
    input  bls_pkg::coord_t end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output bls_pkg::coord_t pixel_x,
    output bls_pkg::coord_t pixel_y,
    output logic            last_pixel
);

    logic          push_valid;
    logic          push_ready;
    bls_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    bls_pkg::cmd_t pop_cmd;

    bls_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    bls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

// File: hw/rtl/bls_checker.sv
module bls_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input bls_pkg::coord_t pixel_x,
    input bls_pkg::coord_t pixel_y,
    input logic            last_pixel
);

    // stalled input transaction stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn while stalled");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(last_pixel))
        else $error("output transaction changed while stalled");

    // queue can only fill up behind a stalled output
    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input backpressure without pending output");

    // nothing emerges in the cycle after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // a fresh pixel needs a prior cycle out of reset
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n))
        else $error("output appeared without a prior cycle out of reset");

endmodule

bind bresenham_line_stepper_top bls_checker u_bls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
);

// File: test/bresenham_line_stepper_top_test.sv
module bresenham_line_stepper_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX = (1 << bls_pkg::COORD_WIDTH) - 1;
    localparam int ITEM_TARGET = 1600;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        bls_pkg::coord_t x;
        bls_pkg::coord_t y;
        logic            last;
    } pixel_t;

    class line_raster_board;
        bls_pkg::coord_t cur_x;
        bls_pkg::coord_t cur_y;
        bls_pkg::coord_t stop_major;
        bls_pkg::coord_t abs_dx;
        bls_pkg::coord_t abs_dy;
        bls_pkg::err_t   err_term;
        logic            x_down;
        logic            y_down;
        logic            x_major;
        logic            busy;
        pixel_t          expected_pixels[$];
        int              mismatches;
        int              loads;
        int              x_major_loads;
        int              empty_loads;
        int              pixels_predicted;
        int              idle_advances;
        int              pixels_checked;
        int              lines_finished;

        function new();
            cur_x = '0;
            cur_y = '0;
            stop_major = '0;
            abs_dx = '0;
            abs_dy = '0;
            err_term = '0;
            x_down = 1'b0;
            y_down = 1'b0;
            x_major = 1'b0;
            busy = 1'b0;
            mismatches = 0;
            loads = 0;
            x_major_loads = 0;
            empty_loads = 0;
            pixels_predicted = 0;
            idle_advances = 0;
            pixels_checked = 0;
            lines_finished = 0;
        endfunction

        function bls_pkg::coord_t nudge(bls_pkg::coord_t c, logic down);
            bls_pkg::coord_t r;
            r = down ? c - 1'b1 : c + 1'b1;
            return r;
        endfunction

        function void note_transaction(bls_pkg::func_t f, bls_pkg::coord_t sx,
                                       bls_pkg::coord_t sy, bls_pkg::coord_t ex,
                                       bls_pkg::coord_t ey);
            int              e;
            int              major_d;
            int              minor_d;
            bls_pkg::coord_t major_next;
            pixel_t          want;
            if (f == bls_pkg::FUNC_LOAD)
            begin
                loads++;
                x_down = ex < sx;
                y_down = ey < sy;
                abs_dx = x_down ? sx - ex : ex - sx;
                abs_dy = y_down ? sy - ey : ey - sy;
                x_major = abs_dx > abs_dy;
                cur_x = sx;
                cur_y = sy;
                if (x_major)
                begin
                    x_major_loads++;
                    stop_major = ex;
                    e = 2 * int'(abs_dy) - int'(abs_dx);
                    busy = abs_dx != '0;
                end
                else
                begin
                    stop_major = ey;
                    e = 2 * int'(abs_dx) - int'(abs_dy);
                    busy = abs_dy != '0;
                end
                err_term = bls_pkg::err_t'(e);
                if (!busy)
                begin
                    empty_loads++;
                end
                return;
            end
            if (!busy)
            begin
                idle_advances++;
                return;
            end
            want.x = cur_x;
            want.y = cur_y;
            major_d = x_major ? int'(abs_dx) : int'(abs_dy);
            minor_d = x_major ? int'(abs_dy) : int'(abs_dx);
            e = int'($signed(err_term));
            if (e > 0)
            begin
                if (x_major)
                begin
                    cur_y = nudge(cur_y, y_down);
                end
                else
                begin
                    cur_x = nudge(cur_x, x_down);
                end
                e -= 2 * major_d;
            end
            e += 2 * minor_d;
            err_term = bls_pkg::err_t'(e);
            if (x_major)
            begin
                cur_x = nudge(cur_x, x_down);
                major_next = cur_x;
            end
            else
            begin
                cur_y = nudge(cur_y, y_down);
                major_next = cur_y;
            end
            want.last = major_next == stop_major;
            if (want.last)
            begin
                busy = 1'b0;
            end
            expected_pixels.push_back(want);
            pixels_predicted++;
        endfunction

        function void check_pixel(bls_pkg::coord_t x, bls_pkg::coord_t y, logic last);
            pixel_t want;
            pixels_checked++;
            if (last)
            begin
                lines_finished++;
            end
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel: x %0d, y %0d, last_pixel %0b", x, y, last);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            if (x !== want.x)
            begin
                $error("pixel_x mismatch: expected %0d, got %0d", want.x, x);
                mismatches++;
            end
            if (y !== want.y)
            begin
                $error("pixel_y mismatch: expected %0d, got %0d", want.y, y);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_pixel mismatch: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic            func;
    bls_pkg::coord_t start_x;
    bls_pkg::coord_t start_y;
    bls_pkg::coord_t end_x;
    bls_pkg::coord_t end_y;
    logic            out_valid;
    logic            out_ready;
    bls_pkg::coord_t pixel_x;
    bls_pkg::coord_t pixel_y;
    logic            last_pixel;

    logic            calm_phase;
    logic            hold_off_request;

    line_raster_board board = new();

    bresenham_line_stepper_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm_phase)
        begin
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic bls_pkg::coord_t pick_near(bls_pkg::coord_t s, int reach);
        int lo;
        int hi;
        lo = int'(s) - reach;
        hi = int'(s) + reach;
        if (lo < 0)
        begin
            lo = 0;
        end
        if (hi > COORD_MAX)
        begin
            hi = COORD_MAX;
        end
        return bls_pkg::coord_t'($urandom_range(hi, lo));
    endfunction

    task automatic send_item(input bls_pkg::func_t f, input bls_pkg::coord_t sx,
                             input bls_pkg::coord_t sy, input bls_pkg::coord_t ex,
                             input bls_pkg::coord_t ey);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_transaction(f, sx, sy, ex, ey);
    endtask

    task automatic load_line(input bls_pkg::coord_t sx, input bls_pkg::coord_t sy,
                             input bls_pkg::coord_t ex, input bls_pkg::coord_t ey);
        send_item(bls_pkg::FUNC_LOAD, sx, sy, ex, ey);
    endtask

    // advance payload is don't-care, so it carries random coordinates
    task automatic advance(input int count);
        repeat (count)
        begin
            send_item(bls_pkg::FUNC_ADVANCE, bls_pkg::coord_t'($urandom),
                      bls_pkg::coord_t'($urandom), bls_pkg::coord_t'($urandom),
                      bls_pkg::coord_t'($urandom));
        end
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin : pixel_sink
        int  sink_wait;
        bit  hold_done;
        sink_wait = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                board.check_pixel(pixel_x, pixel_y, last_pixel);
            end
            if (hold_off_request && !hold_done)
            begin
                hold_done = 1'b1;
                sink_wait = LONG_HOLD_CYCLES;
            end
            else if (sink_wait == 0)
            begin
                sink_wait = pick_gap();
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : run_limit
        #(5_000_000);
        $display("bresenham_line_stepper_top_test NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int              kind;
        int              reach;
        int              r;
        int              pixels;
        int              steps;
        bls_pkg::coord_t sx;
        bls_pkg::coord_t sy;
        bls_pkg::coord_t ex;
        bls_pkg::coord_t ey;

        rst_n = 1'b0;
        in_valid = 1'b0;
        func = bls_pkg::FUNC_LOAD;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        out_ready = 1'b0;
        calm_phase = 1'b0;
        hold_off_request = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle advance, point segment, both majors, equal deltas,
        // corner coordinates, reload while busy
        advance(1);
        load_line(12'd100, 12'd100, 12'd100, 12'd100);
        advance(1);
        load_line(12'd0, 12'd0, 12'd4, 12'd1);
        advance(5);
        load_line(12'd4095, 12'd4095, 12'd4094, 12'd4092);
        advance(3);
        load_line(12'd10, 12'd10, 12'd8, 12'd12);
        advance(2);
        load_line(12'd0, 12'd0, 12'd4095, 12'd4095);
        advance(2);
        load_line(12'd4095, 12'd0, 12'd0, 12'd4095);
        advance(1);
        load_line(12'd4095, 12'd4095, 12'd0, 12'd4094);
        advance(2);

        // receiver stalls for a long stretch while advances keep coming
        calm_phase <= 1'b1;
        hold_off_request <= 1'b1;
        load_line(12'd100, 12'd200, 12'd160, 12'd230);
        advance(40);
        calm_phase <= 1'b0;

        while (board.loads + board.pixels_predicted + board.idle_advances < ITEM_TARGET)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 80)
            begin
                r = $urandom_range(99, 0);
                reach = (r < 85) ? 16 : ((r < 97) ? 200 : COORD_MAX);
                sx = bls_pkg::coord_t'($urandom);
                sy = bls_pkg::coord_t'($urandom);
                ex = pick_near(sx, reach);
                ey = pick_near(sy, reach);
                pixels = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
                r = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
                if (r > pixels)
                begin
                    pixels = r;
                end
                steps = pixels;
                if (steps > 64)
                begin
                    steps = $urandom_range(64, 20);
                end
                r = $urandom_range(9, 0);
                if (r == 0)
                begin
                    steps = $urandom_range(steps, 0);
                end
                else if (r == 1)
                begin
                    steps += $urandom_range(2, 1);
                end
                load_line(sx, sy, ex, ey);
                advance(steps);
            end
            else if (kind < 90)
            begin
                send_item(bls_pkg::func_t'($urandom_range(1, 0)),
                          bls_pkg::coord_t'($urandom), bls_pkg::coord_t'($urandom),
                          bls_pkg::coord_t'($urandom), bls_pkg::coord_t'($urandom));
            end
            else
            begin
                load_line(bls_pkg::coord_t'($urandom), bls_pkg::coord_t'($urandom),
                          bls_pkg::coord_t'($urandom), bls_pkg::coord_t'($urandom));
                advance($urandom_range(5, 1));
            end
            if ($urandom_range(99, 0) < 3)
            begin
                calm_phase <= ~calm_phase;
            end
        end
        in_valid <= 1'b0;

        while (board.expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads (%0d x-major, %0d empty), %0d idle advances",
                 board.loads, board.x_major_loads, board.empty_loads, board.idle_advances);
        $display("checked %0d pixels over %0d completed lines, %0d mismatches",
                 board.pixels_checked, board.lines_finished, board.mismatches);
        if (board.mismatches == 0)
        begin
            $display("bresenham_line_stepper_top_test OK");
        end
        else
        begin
            $display("bresenham_line_stepper_top_test NOT OK");
        end
        $finish;
    end

endmodule
